### rtl/cbb_pkg.sv
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants of the cascaded biquad band-pass block
// Field layout of the coefficient registers, datapath widths and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // datapath and register widths
  localparam int DATA_BITS    = 32;
  localparam int COEF_BITS    = 20;
  localparam int NUM_REGS     = 4;
  localparam int REG_BITS     = 3 * COEF_BITS;
  localparam int CFG_IDX_BITS = 3;

  // field positions inside one coefficient register
  localparam int A1_LSB   = 0;
  localparam int A2_LSB   = COEF_BITS;
  localparam int GAIN_LSB = 2 * COEF_BITS;

  // defaults of the top-level parameters
  localparam int DEF_SECTIONS    = 4;
  localparam int DEF_FRAC_BITS   = 14;
  localparam int DEF_SAMPLE_BITS = 12;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SECTION_ONE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECTION_TWO   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECTION_THREE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SECTION_FOUR  = 3'd3;

  // controller -> datapath commands, one step of a section per flag
  typedef struct packed {
    logic load;     // take a new input word, restart at section 0
    logic mul1;     // prod <= a1*m0, acc <= x<<S
    logic mul2;     // acc <= acc-prod, prod <= a2*m1
    logic sumw;     // w <= (acc-prod)>>>S
    logic numr;     // num <= ((w-m1)<<S)>>>S, shift delay words
    logic mulg;     // prod <= gain*num
    logic sec_inc;  // move on to the next section
    logic out_load; // output register <= prod>>>S
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic sec_last; // working on the last active section
  } stat_t;

endpackage

### rtl/cbb_ctrl.sv
// ----------------------------------------------------------------------------
// cbb_ctrl: sequencer of the cascaded biquad block
// Steps each section through five phases around the shared multiplier and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module cbb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cbb_pkg::stat_t stat,
  output cbb_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL1   = 7'b0000010,
    ST_MUL2   = 7'b0000100,
    ST_SUMW   = 7'b0001000,
    ST_NUMR   = 7'b0010000,
    ST_MULG   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_SUMW;
      end
      ST_SUMW: begin
        cmd.sumw   = 1'b1;
        state_next = ST_NUMR;
      end
      ST_NUMR: begin
        cmd.numr   = 1'b1;
        state_next = ST_MULG;
      end
      ST_MULG: begin
        cmd.mulg = 1'b1;
        if (stat.sec_last) begin
          state_next = ST_FINISH;
        end else begin
          cmd.sec_inc = 1'b1;
          state_next  = ST_MUL1;
        end
      end
      ST_FINISH: begin
        // wait here while the previous result is still unread
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a stalled result holds the sequencer in FINISH
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && !out_ready) |=> state == ST_FINISH)
    else $error("sequencer left FINISH while output was blocked");

  // the last section ends the item
  a_last_section: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULG && stat.sec_last) |=> state == ST_FINISH)
    else $error("last section did not lead to FINISH");

  // an accepted word starts work and blocks further input
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_MUL1 && !in_ready))
    else $error("accepted word did not start the sequence");

  // a finished item always shows up at the output
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished item was not presented");

endmodule

### rtl/cbb_datapath.sv
// ----------------------------------------------------------------------------
// cbb_datapath: arithmetic of the cascaded biquad block
// Coefficient registers, per-section delay words, one shared 32x32 wrapping
// multiplier, accumulator and the output register.
// ----------------------------------------------------------------------------
module cbb_datapath #(
  parameter int SECTIONS    = cbb_pkg::DEF_SECTIONS,
  parameter int FRAC_BITS   = cbb_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = cbb_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cbb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cbb_pkg::REG_BITS-1:0]         cfg_data,
  input  logic [SAMPLE_BITS-1:0]               sample_in,
  input  cbb_pkg::cmd_t                        cmd,
  output cbb_pkg::stat_t                       stat,
  output logic signed [cbb_pkg::DATA_BITS-1:0] filtered_out
);

  localparam int DW    = cbb_pkg::DATA_BITS;
  localparam int CW    = cbb_pkg::COEF_BITS;
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTIONS - 1);

  logic [cbb_pkg::REG_BITS-1:0] coeff_regs [cbb_pkg::NUM_REGS];
  logic [2*DW-1:0]              delay_words [SECTIONS]; // {m1, m0}

  logic [SEC_W-1:0] sec;
  logic [DW-1:0]    x_in, acc, prod, w, num;

  logic [cbb_pkg::REG_BITS-1:0] coef;
  logic [DW-1:0] a1, a2, gain, m0, m1;
  logic [DW-1:0] x_cur, prod_asr, diff, diff_sh, op_a, op_b, prod_full;

  // configuration writes; indexes past the list fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbb_pkg::NUM_REGS; i++) coeff_regs[i] <= '0;
    end else if (cfg_we && cfg_index < cbb_pkg::CFG_IDX_BITS'(cbb_pkg::NUM_REGS)) begin
      coeff_regs[cfg_index[1:0]] <= cfg_data;
    end
  end

  // coefficients and delay words of the current section
  assign coef = coeff_regs[sec];
  assign a1   = {{(DW-CW){coef[cbb_pkg::A1_LSB+CW-1]}},   coef[cbb_pkg::A1_LSB +: CW]};
  assign a2   = {{(DW-CW){coef[cbb_pkg::A2_LSB+CW-1]}},   coef[cbb_pkg::A2_LSB +: CW]};
  assign gain = {{(DW-CW){coef[cbb_pkg::GAIN_LSB+CW-1]}}, coef[cbb_pkg::GAIN_LSB +: CW]};
  assign m0   = delay_words[sec][DW-1:0];
  assign m1   = delay_words[sec][2*DW-1:DW];

  // section input: the sample for the first section, else previous output
  assign prod_asr = DW'($signed(prod) >>> FRAC_BITS);
  assign x_cur    = (sec == '0) ? x_in : prod_asr;

  // numerator {M,0,-M}: (M*w - M*m1) wraps to (w-m1)<<S
  assign diff    = w - m1;
  assign diff_sh = diff << FRAC_BITS;

  // shared multiplier operand select, low 32 bits of the product
  always_comb begin
    op_a = a1;
    op_b = m0;
    if (cmd.mul2) begin
      op_a = a2;
      op_b = m1;
    end else if (cmd.mulg) begin
      op_a = gain;
      op_b = num;
    end
  end
  assign prod_full = DW'(op_a * op_b);

  // section counter
  always_ff @(posedge clk) begin
    if (rst) begin
      sec <= '0;
    end else if (cmd.load) begin
      sec <= '0;
    end else if (cmd.sec_inc) begin
      sec <= sec + SEC_W'(1);
    end
  end
  assign stat.sec_last = (sec == SEC_LAST);

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_in <= {{(DW-SAMPLE_BITS){1'b0}}, sample_in};
    end
    if (cmd.mul1) begin
      acc  <= x_cur << FRAC_BITS;
      prod <= prod_full;
    end
    if (cmd.mul2) begin
      acc  <= acc - prod;
      prod <= prod_full;
    end
    if (cmd.sumw) begin
      w <= DW'($signed(acc - prod) >>> FRAC_BITS);
    end
    if (cmd.numr) begin
      num <= DW'($signed(diff_sh) >>> FRAC_BITS);
    end
    if (cmd.mulg) begin
      prod <= prod_full;
    end
    if (cmd.out_load) begin
      filtered_out <= $signed(prod_asr);
    end
  end

  // delay words: m1 <= m0, m0 <= w
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SECTIONS; i++) delay_words[i] <= '0;
    end else if (cmd.numr) begin
      delay_words[sec] <= {m0, w};
    end
  end

endmodule

### rtl/cascaded_biquad_bandpass_top.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass_top: fixed-point cascaded biquad band-pass filter
//
// Input channel: in_valid/in_ready carry one ADC word on sample_in. Output
// channel: out_valid/out_ready carry one filtered word on filtered_out, one
// output word per input word, in order.
// Configuration: cfg_we writes cfg_data into the coefficient register picked
// by cfg_index (0..3 = sections one to four; a1, a2, gain as signed 20-bit
// fields). Other indexes are dropped. Write only while the block is idle.
// Operation: each section runs five steps on the shared 32x32 multiplier
// (three products and two add/shift steps), then a FINISH step loads the
// output register and sets out_valid. A new word is taken only once the
// sequencer has returned to IDLE from FINISH, so the block does not accept
// a word before it is through with the last one.
// The output register lets the next word enter while a result waits; if the
// receiver stalls longer than one item's work, the sequencer holds the
// finished result internally until the register frees up.
// Reset: synchronous; clears coefficient registers, delay words and all
// handshake state.
// ----------------------------------------------------------------------------
module cascaded_biquad_bandpass_top #(
  parameter int SECTIONS    = cbb_pkg::DEF_SECTIONS,
  parameter int FRAC_BITS   = cbb_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = cbb_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cbb_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cbb_pkg::REG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cbb_pkg::DATA_BITS-1:0] filtered_out
);

  cbb_pkg::cmd_t  cmd;
  cbb_pkg::stat_t stat;

  // sequencer
  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and storage
  cbb_datapath #(
    .SECTIONS    (SECTIONS),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_in    (sample_in),
    .cmd          (cmd),
    .stat         (stat),
    .filtered_out (filtered_out)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the cascaded biquad band-pass filter
// Sends ADC words into the filter over valid/ready and predicts each filtered
// word with a bit-true copy of the four-section direct-form-II cascade. Every
// output word is checked in order. Coefficient banks change between phases
// while the filter is idle. Both channels idle and stall at random, with one
// long receiver hold-off that backs the filter up into its input.
// ----------------------------------------------------------------------------
module tb;
  import cbb_pkg::*;

  localparam int SECTIONS       = DEF_SECTIONS;
  localparam int FRAC_BITS      = DEF_FRAC_BITS;
  localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
  localparam int CLK_HALF       = 5;
  localparam int RST_CYCLES     = 6;
  localparam int SETTLE_CYCLES  = 5 * SECTIONS + 8;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int PHASE_WORDS    = 90;
  localparam int RUN_LIMIT      = 6_000_000;

  localparam logic signed [DATA_BITS-1:0] UNITY = 1 <<< FRAC_BITS;
  localparam logic [COEF_BITS-1:0] FIELD_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] FIELD_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

  // ways to fill the coefficient bank
  typedef enum int {
    BANK_ZERO,
    BANK_BANDPASS,
    BANK_RANDOM,
    BANK_MAX,
    BANK_MIN,
    BANK_ONES,
    BANK_MIXED
  } bank_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [REG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [SAMPLE_BITS-1:0]        sample_in;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [DATA_BITS-1:0]   filtered_out;

  // predictor state: coefficient bank and two delay words per section
  logic [REG_BITS-1:0]           coeff_bank [NUM_REGS];
  logic signed [DATA_BITS-1:0]   section_delay [2*NUM_REGS];
  logic signed [DATA_BITS-1:0]   pending_filtered [$];
  logic signed [DATA_BITS-1:0]   want_filtered;
  logic [SAMPLE_BITS-1:0]        last_word = '0;

  int mismatch_count = 0;
  int rx_hold_req    = 0;
  bit no_idle        = 1'b0;

  cascaded_biquad_bandpass_top #(
    .SECTIONS    (SECTIONS),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .filtered_out (filtered_out)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // run limit
  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // push one ADC word through the cascade, 32-bit wrapping arithmetic
  function automatic logic signed [DATA_BITS-1:0] advance_cascade(
    input logic [SAMPLE_BITS-1:0] word
  );
    logic signed [DATA_BITS-1:0] x, a1, a2, gain, m0, m1, w, num;
    x = $signed({{(DATA_BITS-SAMPLE_BITS){1'b0}}, word});
    for (int k = 0; k < SECTIONS; k++) begin
      a1   = $signed(coeff_bank[k][A1_LSB +: COEF_BITS]);
      a2   = $signed(coeff_bank[k][A2_LSB +: COEF_BITS]);
      gain = $signed(coeff_bank[k][GAIN_LSB +: COEF_BITS]);
      m0   = section_delay[2*k];
      m1   = section_delay[2*k+1];
      // recursive part
      w = UNITY * x - a1 * m0 - a2 * m1;
      w = w >>> FRAC_BITS;
      // numerator {M, 0, -M}
      num = UNITY * w - UNITY * m1;
      num = num >>> FRAC_BITS;
      // section gain
      x = gain * num;
      x = x >>> FRAC_BITS;
      section_delay[2*k+1] = m0;
      section_delay[2*k]   = w;
    end
    return x;
  endfunction

  function automatic logic [REG_BITS-1:0] pack_coeffs(input int a1, input int a2,
                                                      input int gain);
    logic [COEF_BITS-1:0] f1, f2, fg;
    f1 = a1[COEF_BITS-1:0];
    f2 = a2[COEF_BITS-1:0];
    fg = gain[COEF_BITS-1:0];
    return {fg, f2, f1};
  endfunction

  function automatic logic [REG_BITS-1:0] coeff_for(input bank_mode_t mode);
    logic [63:0] raw;
    bank_mode_t pick;
    pick = mode;
    if (pick == BANK_MIXED)
      pick = bank_mode_t'($urandom_range(BANK_ZERO, BANK_ONES));
    raw = {$urandom(), $urandom()};
    case (pick)
      // resonator-like poles, modest gain
      BANK_BANDPASS: return pack_coeffs(0 - int'($urandom_range(8000, 31000)),
                                        int'($urandom_range(8000, 15500)),
                                        int'($urandom_range(200, 20000)));
      BANK_RANDOM:   return raw[REG_BITS-1:0];
      BANK_MAX:      return {3{FIELD_MAX}};
      BANK_MIN:      return {3{FIELD_MIN}};
      BANK_ONES:     return '1;
      default:       return '0;
    endcase
  endfunction

  // random gap length: mostly none or short, a few long
  function automatic int idle_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_word();
    int roll;
    logic [31:0] raw;
    roll = $urandom_range(0, 9);
    raw  = $urandom();
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll < 4) return last_word;
    return raw[SAMPLE_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // shared tasks
  // ---------------------------------------------------------------------------

  // one register write, then the enable goes low again before the task returns
  task automatic write_coeffs(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [REG_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx < NUM_REGS) coeff_bank[idx] = value;
  endtask

  // load all four sections, plus junk at the unused indexes
  task automatic program_bank(input bank_mode_t mode);
    logic [63:0] junk;
    for (int k = REG_SECTION_ONE; k <= REG_SECTION_FOUR; k++)
      write_coeffs(k[CFG_IDX_BITS-1:0], coeff_for(mode));
    for (int k = NUM_REGS; k < 2**CFG_IDX_BITS; k++) begin
      junk = {$urandom(), $urandom()};
      write_coeffs(k[CFG_IDX_BITS-1:0], junk[REG_BITS-1:0]);
    end
  endtask

  // offer one word after a random gap; predict once it is taken
  task automatic send_word(input logic [SAMPLE_BITS-1:0] word);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= word;
    do @(posedge clk); while (!in_ready);
    last_word = word;
    pending_filtered.push_back(advance_cascade(word));
  endtask

  // stop sending and wait for every predicted word to come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_filtered.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero coefficients out of reset: output stays zero, delay words still move
  task automatic test_reset_defaults();
    send_word('0);
    send_word('1);
    send_word(12'ha5a);
    drain_results();
  endtask

  // impulse, step and full-swing toggling through a band-pass bank
  task automatic test_bandpass_response();
    program_bank(BANK_BANDPASS);
    send_word('1);
    repeat (5) send_word('0);
    repeat (4) send_word('1);
    send_word('0);
    send_word('1);
    drain_results();
  endtask

  // extreme coefficient fields: products and sums wrap
  task automatic test_extreme_coeffs();
    bank_mode_t corners [3] = '{BANK_MAX, BANK_MIN, BANK_ONES};
    foreach (corners[i]) begin
      program_bank(corners[i]);
      send_word('1);
      send_word('0);
      send_word('1);
      drain_results();
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    program_bank(BANK_BANDPASS);
    no_idle     = 1'b1;
    rx_hold_req = RX_HOLD_CYCLES;
    repeat (24) send_word(random_word());
    no_idle = 1'b0;
    drain_results();
  endtask

  // random words through a sequence of coefficient banks
  task automatic test_random_phases();
    bank_mode_t plan [8] = '{BANK_BANDPASS, BANK_RANDOM, BANK_MIXED, BANK_BANDPASS,
                             BANK_ONES, BANK_RANDOM, BANK_MIXED, BANK_ZERO};
    foreach (plan[p]) begin
      program_bank(plan[p]);
      // one phase runs with no idling on either side
      no_idle = (p == 3);
      repeat (PHASE_WORDS) send_word(random_word());
      no_idle = 1'b0;
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int stall;
    int hold;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = idle_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output check: each word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_filtered.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual filtered_out %0d",
                 $time, filtered_out);
      end else begin
        want_filtered = pending_filtered.pop_front();
        if (filtered_out !== want_filtered) begin
          mismatch_count++;
          $display("%0t: filtered_out mismatch, expected %0d actual %0d",
                   $time, want_filtered, filtered_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    foreach (coeff_bank[i]) coeff_bank[i] = '0;
    foreach (section_delay[i]) section_delay[i] = '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_bandpass_response();
    test_extreme_coeffs();
    test_backpressure();
    test_random_phases();
    drain_results();

    if (mismatch_count == 0 && pending_filtered.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
